// ===== rtl/wrvt_pkg.sv =====
package wrvt_pkg;

  // Fraction width of the sample, weight, mean and weight-sum fixed-point fields.
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int WSUM_W    = 32;
  localparam int SPREAD_W  = 48;
  localparam int IDX_W     = 12;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;

  localparam int DEF_CELL_COUNT = 4096;

  // Datapath widths.
  localparam int NUM_W  = 2 * VAL_W;
  localparam int PROD_W = 3 * VAL_W;
  localparam int DIV_DW = SPREAD_W + 1;
  localparam int DIV_QW = VAL_W + 1;
  localparam int DIV_RW = WSUM_W + 1;

  localparam logic [VAL_W-1:0]    ONE        = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [WSUM_W-1:0]   WSUM_MAX   = '1;
  localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0]    mean;
    logic [WSUM_W-1:0]   wsum;
    logic [SPREAD_W-1:0] spread;
  } cell_t;

  typedef struct packed {
    logic               start;
    logic [DIV_DW-1:0]  dividend;
    logic [WSUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              ovf;
    logic [DIV_QW-1:0] quotient;
  } div_resp_t;

endpackage

// ===== rtl/wrvt_if.sv =====
interface wrvt_in_if;
  logic                           valid;
  logic                           ready;
  logic [wrvt_pkg::CMD_W-1:0]     command;
  logic [wrvt_pkg::IDX_W-1:0]     cell_index;
  logic [wrvt_pkg::VAL_W-1:0]     sample_value;
  logic [wrvt_pkg::VAL_W-1:0]     sample_weight;

  modport source (output valid, command, cell_index, sample_value, sample_weight,
                  input ready);
  modport sink   (input valid, command, cell_index, sample_value, sample_weight,
                  output ready);
endinterface

interface wrvt_out_if;
  logic                           valid;
  logic                           ready;
  logic [wrvt_pkg::VAL_W-1:0]     mean_out;
  logic [wrvt_pkg::VAL_W-1:0]     normalized_variance;
  logic [wrvt_pkg::WSUM_W-1:0]    weight_total;
  logic [wrvt_pkg::STAT_W-1:0]    status;

  modport source (output valid, mean_out, normalized_variance, weight_total, status,
                  input ready);
  modport sink   (input valid, mean_out, normalized_variance, weight_total, status,
                  output ready);
endinterface

// ===== rtl/wrvt_div.sv =====
module wrvt_div (
  input  logic                clk,
  input  logic                rst_n,
  input  wrvt_pkg::div_req_t  req,
  output wrvt_pkg::div_resp_t resp
);

  localparam int CNT_W = $clog2(wrvt_pkg::DIV_QW);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_DONE} dstate_t;

  dstate_t                       dstate_r;
  logic [wrvt_pkg::DIV_RW-1:0]   rem_r;
  logic [wrvt_pkg::DIV_QW-1:0]   dvd_r;
  logic [wrvt_pkg::WSUM_W-1:0]   dvs_r;
  logic [wrvt_pkg::DIV_QW-1:0]   q_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          ovf_r;

  logic [wrvt_pkg::DIV_RW-1:0]   rem_sh;
  logic [wrvt_pkg::DIV_RW-1:0]   dvs_ext;
  logic                          fits;

  // One quotient bit per cycle, restoring form.
  assign dvs_ext = {1'b0, dvs_r};
  assign rem_sh  = {rem_r[wrvt_pkg::DIV_RW-2:0], dvd_r[wrvt_pkg::DIV_QW-1]};
  assign fits    = rem_sh >= dvs_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
    end else begin
      case (dstate_r)
        D_IDLE: begin
          if (req.start) begin
            dvs_r    <= req.divisor;
            rem_r    <= wrvt_pkg::DIV_RW'(req.dividend[wrvt_pkg::DIV_DW-1:wrvt_pkg::DIV_QW]);
            dvd_r    <= req.dividend[wrvt_pkg::DIV_QW-1:0];
            dstate_r <= D_CHECK;
          end
        end
        D_CHECK: begin
          // A quotient too wide for the shift register is flagged instead.
          ovf_r    <= rem_r >= dvs_ext;
          q_r      <= '0;
          cnt_r    <= '0;
          dstate_r <= (rem_r >= dvs_ext) ? D_DONE : D_RUN;
        end
        D_RUN: begin
          rem_r <= fits ? (rem_sh - dvs_ext) : rem_sh;
          dvd_r <= {dvd_r[wrvt_pkg::DIV_QW-2:0], 1'b0};
          q_r   <= {q_r[wrvt_pkg::DIV_QW-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(wrvt_pkg::DIV_QW - 1)) begin
            dstate_r <= D_DONE;
          end
        end
        D_DONE: begin
          dstate_r <= D_IDLE;
        end
        default: begin
          dstate_r <= D_IDLE;
        end
      endcase
    end
  end

  assign resp.busy     = dstate_r != D_IDLE;
  assign resp.done     = dstate_r == D_DONE;
  assign resp.ovf      = ovf_r;
  assign resp.quotient = q_r;

endmodule

// ===== rtl/weighted_running_variance_table_unit.sv =====
// Channel  Direction  Handshake      Payload
// in_chan  sink       valid / ready  command, cell_index, sample_value, sample_weight
// out_chan source     valid / ready  mean_out, normalized_variance, weight_total, status
//
// Each in_chan transaction gives one out_chan transaction. An accumulate presents its result
// after a shift-add pass, a restoring divide and a second shift-add pass; a read after one
// restoring divide, which skips its shift steps when the quotient overflows and is clamped.
// Clear, spare commands, out-of-range cells and empty weight sums go from decode straight to
// the output state, and in_chan is ready again in the same cycle as the result is presented.
// After reset a clearing pass zeroes all min(CELL_COUNT, 4096) entries, one per cycle, with
// in_chan.ready low. The output register lets a stalled out_chan hold the unit only once the next result is ready.
module weighted_running_variance_table_unit #(
  parameter int CELL_COUNT = wrvt_pkg::DEF_CELL_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  wrvt_in_if.sink     in_chan,
  wrvt_out_if.source  out_chan
);

  // The table never needs more entries than the cell index can address.
  localparam int IDX_RANGE = 1 << wrvt_pkg::IDX_W;
  localparam int MEM_DEPTH = (CELL_COUNT < IDX_RANGE) ? CELL_COUNT : IDX_RANGE;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LIM_W     = 21;
  localparam logic [LIM_W-1:0] CELL_LIMIT = LIM_W'(CELL_COUNT);
  localparam int MCNT_W    = $clog2(wrvt_pkg::VAL_W);
  localparam int VW        = wrvt_pkg::VAL_W;
  localparam int PW        = wrvt_pkg::PROD_W;
  localparam int SW        = wrvt_pkg::SPREAD_W;
  localparam int WW        = wrvt_pkg::WSUM_W;
  localparam logic [PW-1:0] HALF = PW'(wrvt_pkg::ONE >> 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_MUL, S_DIV_GO, S_DIV_WAIT, S_UPDATE, S_ACCUM, S_OUT
  } state_t;

  function automatic logic [VW-1:0] clamp_one(input logic [VW-1:0] v);
    return (v > wrvt_pkg::ONE) ? wrvt_pkg::ONE : v;
  endfunction

  // Cell table.
  wrvt_pkg::cell_t mem [MEM_DEPTH];
  wrvt_pkg::cell_t rdata_r;
  wrvt_pkg::cell_t mem_wdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;

  state_t                        state_r;
  logic [AW-1:0]                 clr_addr_r;
  logic [wrvt_pkg::CMD_W-1:0]    cmd_r;
  logic [wrvt_pkg::IDX_W-1:0]    idx_r;
  logic [VW-1:0]                 x_r;
  logic [VW-1:0]                 w_r;
  logic [VW-1:0]                 m_r;
  logic [WW-1:0]                 ws_r;
  logic [SW-1:0]                 spread_r;
  logic [wrvt_pkg::STAT_W-1:0]   stat_r;
  logic                          up_r;
  logic [VW-1:0]                 d1_r;
  logic [VW-1:0]                 step_r;
  logic [VW-1:0]                 mn_r;

  // Shift-add multiplier: the multiplicand walks left, the multiplier right.
  logic [PW-1:0]                 mc_r;
  logic [VW-1:0]                 mp_r;
  logic [PW-1:0]                 acc_r;
  logic [MCNT_W-1:0]             mcnt_r;
  logic                          mul_pass_r;

  logic [VW-1:0]                 res_mean_r;
  logic [VW-1:0]                 res_var_r;
  logic [WW-1:0]                 res_wsum_r;
  logic [wrvt_pkg::STAT_W-1:0]   res_stat_r;

  logic                          out_valid_r;
  logic [VW-1:0]                 out_mean_r;
  logic [VW-1:0]                 out_var_r;
  logic [WW-1:0]                 out_wsum_r;
  logic [wrvt_pkg::STAT_W-1:0]   out_stat_r;

  wrvt_pkg::div_req_t            div_req;
  wrvt_pkg::div_resp_t           div_resp;

  logic                          in_range;
  logic [WW:0]                   ws_sum;
  logic [WW-1:0]                 ws_new;
  logic                          up_now;
  logic [VW-1:0]                 d1_now;
  logic [VW:0]                   mn_sum;
  logic [SW:0]                   spread_sum;
  logic [SW-1:0]                 spread_nxt;
  logic [wrvt_pkg::DIV_QW-1:0]   q;

  wrvt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .resp  (div_resp)
  );

  // The table is only written outside the idle state, so the read issued at
  // acceptance never collides with a write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[in_chan.cell_index[AW-1:0]];
  end

  assign in_range = LIM_W'(idx_r) < CELL_LIMIT;

  // Weight sum update, saturating at the top of the Q16.16 range.
  assign ws_sum = {1'b0, rdata_r.wsum} + (WW + 1)'(w_r);
  assign ws_new = ws_sum[WW] ? wrvt_pkg::WSUM_MAX : ws_sum[WW-1:0];

  // Distance of the sample from the stored mean, with its direction.
  assign up_now = x_r >= rdata_r.mean;
  assign d1_now = up_now ? (x_r - rdata_r.mean) : (rdata_r.mean - x_r);

  // The step never overshoots the sample, so the new mean stays in range.
  assign mn_sum = up_r ? ({1'b0, m_r} + {1'b0, step_r}) : ({1'b0, m_r} - {1'b0, step_r});

  // Spread term is the second product shifted down by the fraction width; the
  // rounding half was preloaded into the accumulator.
  assign spread_sum = {1'b0, spread_r} + (SW + 1)'(acc_r[PW-1:wrvt_pkg::FRAC_BITS]);
  assign spread_nxt = spread_sum[SW] ? wrvt_pkg::SPREAD_MAX : spread_sum[SW-1:0];

  assign q = div_resp.quotient;

  // Divider request: the read divides the spread sum, the accumulate divides
  // the first product, both by the weight sum with half of it added for rounding.
  always_comb begin
    div_req.start   = state_r == S_DIV_GO;
    div_req.divisor = ws_r;
    if (cmd_r == wrvt_pkg::CMD_READ) begin
      div_req.dividend = wrvt_pkg::DIV_DW'(spread_r) + wrvt_pkg::DIV_DW'(ws_r >> 1);
    end else begin
      div_req.dividend = wrvt_pkg::DIV_DW'(acc_r[wrvt_pkg::NUM_W-1:0])
                       + wrvt_pkg::DIV_DW'(ws_r >> 1);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      S_DECODE: begin
        mem_we = in_range && (cmd_r == wrvt_pkg::CMD_CLEAR);
      end
      S_ACCUM: begin
        mem_we           = 1'b1;
        mem_wdata.mean   = mn_r;
        mem_wdata.wsum   = ws_r;
        mem_wdata.spread = spread_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The output state reloads the register itself when the result is taken.
      if (out_valid_r && out_chan.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(MEM_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_chan.valid) begin
            cmd_r   <= in_chan.command;
            idx_r   <= in_chan.cell_index;
            x_r     <= clamp_one(in_chan.sample_value);
            w_r     <= clamp_one(in_chan.sample_weight);
            state_r <= S_DECODE;
          end
        end

        S_DECODE: begin
          m_r      <= rdata_r.mean;
          spread_r <= rdata_r.spread;
          ws_r     <= rdata_r.wsum;
          if (!in_range) begin
            res_mean_r <= '0;
            res_var_r  <= '0;
            res_wsum_r <= '0;
            res_stat_r <= wrvt_pkg::ST_OK;
            state_r    <= S_OUT;
          end else begin
            case (cmd_r)
              wrvt_pkg::CMD_ACCUM: begin
                ws_r   <= ws_new;
                stat_r <= ws_sum[WW] ? wrvt_pkg::ST_SAT : wrvt_pkg::ST_OK;
                if (ws_new == '0) begin
                  res_mean_r <= rdata_r.mean;
                  res_var_r  <= '0;
                  res_wsum_r <= '0;
                  res_stat_r <= wrvt_pkg::ST_ZERO;
                  state_r    <= S_OUT;
                end else begin
                  up_r       <= up_now;
                  d1_r       <= d1_now;
                  mc_r       <= PW'(w_r);
                  mp_r       <= d1_now;
                  acc_r      <= '0;
                  mcnt_r     <= '0;
                  mul_pass_r <= 1'b0;
                  state_r    <= S_MUL;
                end
              end
              wrvt_pkg::CMD_READ: begin
                if (rdata_r.wsum == '0) begin
                  res_mean_r <= rdata_r.mean;
                  res_var_r  <= '0;
                  res_wsum_r <= '0;
                  res_stat_r <= wrvt_pkg::ST_ZERO;
                  state_r    <= S_OUT;
                end else begin
                  state_r <= S_DIV_GO;
                end
              end
              wrvt_pkg::CMD_CLEAR: begin
                res_mean_r <= '0;
                res_var_r  <= '0;
                res_wsum_r <= '0;
                res_stat_r <= wrvt_pkg::ST_OK;
                state_r    <= S_OUT;
              end
              default: begin
                res_mean_r <= rdata_r.mean;
                res_var_r  <= '0;
                res_wsum_r <= rdata_r.wsum;
                res_stat_r <= wrvt_pkg::ST_OK;
                state_r    <= S_OUT;
              end
            endcase
          end
        end

        S_MUL: begin
          acc_r  <= acc_r + (mp_r[0] ? mc_r : '0);
          mc_r   <= {mc_r[PW-2:0], 1'b0};
          mp_r   <= {1'b0, mp_r[VW-1:1]};
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == MCNT_W'(VW - 1)) begin
            state_r <= mul_pass_r ? S_ACCUM : S_DIV_GO;
          end
        end

        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_resp.done) begin
            if (cmd_r == wrvt_pkg::CMD_READ) begin
              res_mean_r <= m_r;
              res_wsum_r <= ws_r;
              res_stat_r <= (ws_r == wrvt_pkg::WSUM_MAX) ? wrvt_pkg::ST_SAT : wrvt_pkg::ST_OK;
              if (div_resp.ovf || (q > wrvt_pkg::DIV_QW'(wrvt_pkg::ONE))) begin
                res_var_r <= wrvt_pkg::ONE;
              end else begin
                res_var_r <= q[VW-1:0];
              end
              state_r <= S_OUT;
            end else begin
              // The mean step is limited to the distance from the sample.
              if (div_resp.ovf || (q > wrvt_pkg::DIV_QW'(d1_r))) begin
                step_r <= d1_r;
              end else begin
                step_r <= q[VW-1:0];
              end
              state_r <= S_UPDATE;
            end
          end
        end

        S_UPDATE: begin
          mn_r       <= mn_sum[VW] ? wrvt_pkg::ONE : clamp_one(mn_sum[VW-1:0]);
          mc_r       <= PW'(acc_r[wrvt_pkg::NUM_W-1:0]);
          mp_r       <= d1_r - step_r;
          acc_r      <= HALF;
          mcnt_r     <= '0;
          mul_pass_r <= 1'b1;
          state_r    <= S_MUL;
        end

        S_ACCUM: begin
          res_mean_r <= mn_r;
          res_var_r  <= '0;
          res_wsum_r <= ws_r;
          res_stat_r <= stat_r;
          state_r    <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_mean_r  <= res_mean_r;
            out_var_r   <= res_var_r;
            out_wsum_r  <= res_wsum_r;
            out_stat_r  <= res_stat_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready                = state_r == S_IDLE;
  assign out_chan.valid               = out_valid_r;
  assign out_chan.mean_out            = out_mean_r;
  assign out_chan.normalized_variance = out_var_r;
  assign out_chan.weight_total        = out_wsum_r;
  assign out_chan.status              = out_stat_r;

  // A new result is only ever presented from the output state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result presented outside the output state");

  // The divider is never restarted while a division is still running.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_GO) |-> !div_resp.busy)
    else $error("divider started while busy");

  // The variance is clamped to one.
  a_var_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_var_r <= wrvt_pkg::ONE))
    else $error("normalized variance above one");

  // A zero weight sum status always reports a zero weight total.
  a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == wrvt_pkg::ST_ZERO)) |-> (out_wsum_r == '0))
    else $error("zero weight status with non-zero weight total");

  // No table write while a transaction may be accepted and read.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE))
    else $error("table written while idle");

endmodule
